FILE: rtl/pbf_pkg.sv
package pbf_pkg;

   // Field widths fixed by the item and register formats.
   localparam int COORD_W = 24;
   localparam int SIZE_W  = 12;
   localparam int GAIN_W  = 16;
   localparam int ACC_W   = 40;

   // Register indexes on the configuration port.
   localparam logic [2:0] REG_GAIN_PROP     = 3'd0;
   localparam logic [2:0] REG_GAIN_INTEG    = 3'd1;
   localparam logic [2:0] REG_GAIN_DERIV    = 3'd2;
   localparam logic [2:0] REG_TIME_STEP     = 3'd3;
   localparam logic [2:0] REG_INV_TIME_STEP = 3'd4;

   // Sequencer steps shared by both axis lanes.
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_MUL1,
      ST_MUL2,
      ST_MUL3,
      ST_SUM,
      ST_MOVE,
      ST_OUT
   } state_type;

   // Step strobes sent from the sequencer to each lane.
   typedef struct packed {
      logic load;
      logic mul1;
      logic mul2;
      logic mul3;
      logic sum;
      logic move;
   } lane_ctrl_type;

   // Controller settings as seen by the lanes.
   typedef struct packed {
      logic signed [GAIN_W-1:0] gain_prop;
      logic signed [GAIN_W-1:0] gain_integ;
      logic signed [GAIN_W-1:0] gain_deriv;
      logic [GAIN_W-1:0]        time_step;
      logic [GAIN_W-1:0]        inv_time_step;
   } cfg_type;

   // Clamp a signed value to the signed 24-bit range.
   function automatic logic signed [COORD_W-1:0] sat_24(input logic signed [47:0] x);
      logic signed [COORD_W-1:0] r;
      if (x > 48'sd8388607) begin
         r = 24'sh7FFFFF;
      end else if (x < -48'sd8388608) begin
         r = 24'sh800000;
      end else begin
         r = x[COORD_W-1:0];
      end
      return r;
   endfunction

   // Clamp a signed value to the signed 40-bit range.
   function automatic logic signed [ACC_W-1:0] sat_40(input logic signed [47:0] x);
      logic signed [ACC_W-1:0] r;
      if (x > 48'sd549755813887) begin
         r = 40'sh7FFFFFFFFF;
      end else if (x < -48'sd549755813888) begin
         r = 40'sh8000000000;
      end else begin
         r = x[ACC_W-1:0];
      end
      return r;
   endfunction

endpackage

FILE: rtl/pbf_lane.sv
module pbf_lane import pbf_pkg::*; (
   input  logic                      clock,
   input  logic                      reset,
   input  lane_ctrl_type             ctrl,
   input  cfg_type                   cfg,
   input  logic signed [COORD_W-1:0] target,
   output logic signed [COORD_W-1:0] centre,
   output logic signed [COORD_W-1:0] speed
);

   // Axis state kept across items.
   logic signed [COORD_W-1:0] centre_ff, centre_in;
   logic signed [ACC_W-1:0]   acc_ff, acc_in;
   logic signed [COORD_W-1:0] last_err_ff;

   // Working registers of one item.
   logic signed [COORD_W-1:0] err_ff, err_in;
   logic signed [COORD_W:0]   derr_ff, derr_in;
   logic signed [39:0]        prop_ff;
   logic signed [40:0]        tstep_ff;
   logic signed [41:0]        d1_ff;
   logic signed [57:0]        d2_ff;
   logic signed [47:0]        integ_ff;
   logic signed [COORD_W-1:0] speed_ff, speed_in;

   logic signed [COORD_W:0]   diff;
   logic signed [16:0]        time_step_s;
   logic signed [16:0]        inv_step_s;
   logic signed [41:0]        acc_sum;
   logic signed [55:0]        integ_prod;
   logic signed [59:0]        pid_sum;
   logic signed [43:0]        pid_shift;
   logic signed [COORD_W:0]   move_sum;

   assign time_step_s = {1'b0, cfg.time_step};
   assign inv_step_s  = {1'b0, cfg.inv_time_step};

   // Error and its change against the previous item.
   always_comb begin
      diff     = 25'(target) - 25'(centre_ff);
      err_in   = sat_24(48'(diff));
      derr_in  = 25'(err_in) - 25'(last_err_ff);
   end

   // Integral update, integral product, weighted sum and centre move.
   always_comb begin
      acc_sum    = 42'(acc_ff) + 42'(tstep_ff);
      acc_in     = sat_40(48'(acc_sum));
      integ_prod = acc_ff * cfg.gain_integ;
      pid_sum    = 60'(prop_ff) * 60'sd256 + 60'(integ_ff) + 60'(d2_ff);
      pid_shift  = 44'(pid_sum >>> 16);
      speed_in   = sat_24(48'(pid_shift));
      move_sum   = 25'(centre_ff) + 25'(speed_ff);
      centre_in  = sat_24(48'(move_sum));
   end

   // Axis state registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         centre_ff   <= '0;
         acc_ff      <= '0;
         last_err_ff <= '0;
      end else begin
         if (ctrl.mul2) begin
            acc_ff <= acc_in;
         end
         if (ctrl.sum) begin
            last_err_ff <= err_ff;
         end
         if (ctrl.move) begin
            centre_ff <= centre_in;
         end
      end
   end

   // Multiply chain, one product layer per step.
   always_ff @(posedge clock) begin
      if (ctrl.load) begin
         err_ff  <= err_in;
         derr_ff <= derr_in;
      end
      if (ctrl.mul1) begin
         prop_ff  <= err_ff * cfg.gain_prop;
         tstep_ff <= err_ff * time_step_s;
         d1_ff    <= derr_ff * inv_step_s;
      end
      if (ctrl.mul2) begin
         d2_ff <= d1_ff * cfg.gain_deriv;
      end
      if (ctrl.mul3) begin
         integ_ff <= 48'(integ_prod >>> 8);
      end
      if (ctrl.sum) begin
         speed_ff <= speed_in;
      end
   end

   assign centre = centre_ff;
   assign speed  = speed_ff;

endmodule

FILE: rtl/pbf_merge.sv
module pbf_merge import pbf_pkg::*; #(
   parameter int FRAC_BITS = 8
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      load,
   input  logic signed [COORD_W-1:0] centre_x,
   input  logic signed [COORD_W-1:0] centre_y,
   input  logic signed [COORD_W-1:0] speed_x,
   input  logic signed [COORD_W-1:0] speed_y,
   input  logic [SIZE_W-2:0]         half_w_px,
   input  logic [SIZE_W-2:0]         half_h_px,
   input  logic                      rsp_tready,
   output logic                      rsp_tvalid,
   // center_x, center_y, speed_x, speed_y, corner_low_x, corner_low_y,
   // corner_high_x, corner_high_y, 24 bits each from the lowest bit up
   output logic [8*COORD_W-1:0]      rsp_tdata
);

   logic                      valid_ff;
   logic signed [COORD_W-1:0] cx_ff, cy_ff, sx_ff, sy_ff;
   logic signed [COORD_W-1:0] lo_x_ff, lo_y_ff, hi_x_ff, hi_y_ff;

   logic [COORD_W-1:0]        half_w, half_h;
   logic signed [COORD_W:0]   half_w_s, half_h_s;
   logic signed [COORD_W:0]   lo_x, lo_y, hi_x, hi_y;

   // Half sizes in coordinate units, then corners around the new centre.
   always_comb begin
      half_w   = COORD_W'(half_w_px) << FRAC_BITS;
      half_h   = COORD_W'(half_h_px) << FRAC_BITS;
      half_w_s = {1'b0, half_w};
      half_h_s = {1'b0, half_h};
      lo_x     = 25'(centre_x) - half_w_s;
      lo_y     = 25'(centre_y) - half_h_s;
      hi_x     = 25'(centre_x) + half_w_s;
      hi_y     = 25'(centre_y) + half_h_s;
   end

   // Result valid flag.
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (load) begin
         valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         valid_ff <= 1'b0;
      end
   end

   // Result payload register.
   always_ff @(posedge clock) begin
      if (load) begin
         cx_ff   <= centre_x;
         cy_ff   <= centre_y;
         sx_ff   <= speed_x;
         sy_ff   <= speed_y;
         lo_x_ff <= sat_24(48'(lo_x));
         lo_y_ff <= sat_24(48'(lo_y));
         hi_x_ff <= sat_24(48'(hi_x));
         hi_y_ff <= sat_24(48'(hi_y));
      end
   end

   assign rsp_tvalid = valid_ff;
   assign rsp_tdata  = {hi_y_ff, hi_x_ff, lo_y_ff, lo_x_ff, sy_ff, sx_ff, cy_ff, cx_ff};

endmodule

FILE: rtl/pid_box_position_follower_core.sv
// Channel   | Direction | Payload (lowest bit first)
// req_      | in        | target_x 24, target_y 24, box_width 12, box_height 12
// rsp_      | out       | center_x/y, speed_x/y, corner_low_x/y, corner_high_x/y (24 each)
// csr_      | in        | gain_prop, gain_integ, gain_deriv, time_step, inv_time_step
//
// An item is accepted and then steps through the multiply chain of each
// axis (error products, derivative product, integral product, weighted
// sum, centre move) and the output step; no new item is accepted until
// the output step is left. The x and y lanes run side by side. Reset
// clears the centre, integral and last error of both axes and loads the
// register defaults. The next item is accepted while a result still waits;
// the sequencer holds in its last step only when the result register is still full.
module pid_box_position_follower_core import pbf_pkg::*; #(
   parameter int FRAC_BITS = 8
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_tvalid,
   output logic                 req_tready,
   // target_x [23:0], target_y [47:24], box_width [59:48], box_height [71:60]
   input  logic [71:0]          req_tdata,
   output logic                 rsp_tvalid,
   input  logic                 rsp_tready,
   // center_x, center_y, speed_x, speed_y, corner_low_x, corner_low_y,
   // corner_high_x, corner_high_y, 24 bits each from the lowest bit up
   output logic [8*COORD_W-1:0] rsp_tdata,
   input  logic                 csr_psel,
   input  logic                 csr_penable,
   input  logic                 csr_pwrite,
   input  logic [4:0]           csr_paddr,
   input  logic [31:0]          csr_pwdata,
   output logic [31:0]          csr_prdata,
   output logic                 csr_pready
);

   state_type     state_ff, state_in;
   lane_ctrl_type ctrl;
   cfg_type       cfg_ff;
   logic          out_load;
   logic          req_fire;
   logic          csr_write;
   logic [2:0]    csr_index;

   logic [SIZE_W-2:0]         half_w_ff, half_h_ff;
   logic signed [COORD_W-1:0] centre_x, centre_y, speed_x, speed_y;

   assign req_fire  = req_tvalid && req_tready;
   assign csr_pready = 1'b1;
   assign csr_write = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_index = csr_paddr[4:2];

   // Register file writes.
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.gain_prop     <= 16'sd256;
         cfg_ff.gain_integ    <= 16'sd0;
         cfg_ff.gain_deriv    <= 16'sd0;
         cfg_ff.time_step     <= 16'd2185;
         cfg_ff.inv_time_step <= 16'd7680;
      end else if (csr_write) begin
         case (csr_index)
            REG_GAIN_PROP:     cfg_ff.gain_prop     <= csr_pwdata[15:0];
            REG_GAIN_INTEG:    cfg_ff.gain_integ    <= csr_pwdata[15:0];
            REG_GAIN_DERIV:    cfg_ff.gain_deriv    <= csr_pwdata[15:0];
            REG_TIME_STEP:     cfg_ff.time_step     <= csr_pwdata[15:0];
            REG_INV_TIME_STEP: cfg_ff.inv_time_step <= csr_pwdata[15:0];
            default: begin
            end
         endcase
      end
   end

   // Register file reads.
   always_comb begin
      case (csr_index)
         REG_GAIN_PROP:     csr_prdata = {16'd0, cfg_ff.gain_prop};
         REG_GAIN_INTEG:    csr_prdata = {16'd0, cfg_ff.gain_integ};
         REG_GAIN_DERIV:    csr_prdata = {16'd0, cfg_ff.gain_deriv};
         REG_TIME_STEP:     csr_prdata = {16'd0, cfg_ff.time_step};
         REG_INV_TIME_STEP: csr_prdata = {16'd0, cfg_ff.inv_time_step};
         default:           csr_prdata = 32'd0;
      endcase
   end

   // Sequencer state register.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Sequencer next state and step strobes.
   always_comb begin
      state_in   = state_ff;
      ctrl       = '0;
      out_load   = 1'b0;
      req_tready = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               ctrl.load = 1'b1;
               state_in  = ST_MUL1;
            end
         end
         ST_MUL1: begin
            ctrl.mul1 = 1'b1;
            state_in  = ST_MUL2;
         end
         ST_MUL2: begin
            ctrl.mul2 = 1'b1;
            state_in  = ST_MUL3;
         end
         ST_MUL3: begin
            ctrl.mul3 = 1'b1;
            state_in  = ST_SUM;
         end
         ST_SUM: begin
            ctrl.sum = 1'b1;
            state_in = ST_MOVE;
         end
         ST_MOVE: begin
            ctrl.move = 1'b1;
            state_in  = ST_OUT;
         end
         ST_OUT: begin
            if (!rsp_tvalid || rsp_tready) begin
               out_load = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Half sizes in whole pixels, kept for the corner step.
   always_ff @(posedge clock) begin
      if (req_fire) begin
         half_w_ff <= req_tdata[59:49];
         half_h_ff <= req_tdata[71:61];
      end
   end

   pbf_lane u_lane_x (
      .clock  (clock),
      .reset  (reset),
      .ctrl   (ctrl),
      .cfg    (cfg_ff),
      .target (req_tdata[23:0]),
      .centre (centre_x),
      .speed  (speed_x)
   );

   pbf_lane u_lane_y (
      .clock  (clock),
      .reset  (reset),
      .ctrl   (ctrl),
      .cfg    (cfg_ff),
      .target (req_tdata[47:24]),
      .centre (centre_y),
      .speed  (speed_y)
   );

   pbf_merge #(
      .FRAC_BITS (FRAC_BITS)
   ) u_merge (
      .clock      (clock),
      .reset      (reset),
      .load       (out_load),
      .centre_x   (centre_x),
      .centre_y   (centre_y),
      .speed_x    (speed_x),
      .speed_y    (speed_y),
      .half_w_px  (half_w_ff),
      .half_h_px  (half_h_ff),
      .rsp_tready (rsp_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tdata  (rsp_tdata)
   );

`ifndef NO_ASSERTIONS
   // An accepted item always starts the multiply chain next.
   a_accept_starts : assert property (@(posedge clock) disable iff (reset)
      req_fire |=> state_ff == ST_MUL1)
      else $error("accepted item did not start the sequence");

   // A new result appears only out of the final step.
   a_result_source : assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_tvalid) |-> $past(state_ff) == ST_OUT)
      else $error("result raised outside the final step");

   // A full result register keeps the sequencer waiting in its final step.
   a_stall_holds : assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_OUT && rsp_tvalid && !rsp_tready) |=> state_ff == ST_OUT)
      else $error("sequencer left the final step while the result was stalled");
`endif

endmodule
